// ----- hdl/multi_turn_angle_tracker_core_defines.svh -----
// assertion macros used by the angle tracker core
`ifndef MULTI_TURN_ANGLE_TRACKER_CORE_DEFINES_SVH
`define MULTI_TURN_ANGLE_TRACKER_CORE_DEFINES_SVH

// checked only while out of reset
`define MTAT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MTAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mtat_pkg.sv -----
// package with widths, constants and types of the angle tracker
`timescale 1ns / 1ps
`default_nettype none

package mtat_pkg;

    localparam int SENSOR_W     = 3;
    localparam int RAW_W        = 12;
    localparam int ANGLE_W      = 34;
    localparam int TURN_W       = 16;
    localparam int OFFSET_W     = 24;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_REGS     = 7;
    localparam int NUM_SENSORS_DEF = 7;

    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 56;

    localparam logic [RAW_W-1:0] WRAP_LOW  = 12'd100;
    localparam logic [RAW_W-1:0] WRAP_HIGH = 12'd4000;
    localparam int UNITS_PER_COUNT = 45;
    localparam int TURN_SHIFT      = 12;

    localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7fff;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [TURN_W-1:0]  turns;
        logic signed [ANGLE_W-1:0] angle;
    } t_unwrap_res;

endpackage

`default_nettype wire

// ----- hdl/multi_turn_angle_tracker_core.sv -----
// top level of the multi-turn angle tracker: per-channel state, offsets and stream stages
// a sample passes the input register, then the result register, before result valid
// throughput: one request per cycle unless results stall, via state read-modify-write
// state is written when a sample moves to the result register, so back-to-back samples of
// one channel see the updated turn count
// reset (synchronous, active low) clears turn counts, last samples, offsets and valid flags
`timescale 1ns / 1ps
`default_nettype none
`include "multi_turn_angle_tracker_core_defines.svh"

module multi_turn_angle_tracker_core
    import mtat_pkg::*;
#(
    parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [OFFSET_W-1:0]  i_cfg_data,
    // sample stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // sensor_index [2:0], raw_angle [14:3], zero fill [15]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // sensor_echo [2:0], angle_fixed [36:3], turn_total [52:37], zero fill [55:53]
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    logic                        r_in_valid;
    logic [SENSOR_W-1:0]         r_in_ch;
    logic [RAW_W-1:0]            r_in_raw;

    logic                        r_out_valid;
    logic [SENSOR_W-1:0]         r_out_ch;
    logic signed [ANGLE_W-1:0]   r_out_angle;
    logic signed [TURN_W-1:0]    r_out_turns;

    logic [RAW_W-1:0]            r_prev  [NUM_SENSORS];
    logic signed [TURN_W-1:0]    r_turns [NUM_SENSORS];
    logic signed [OFFSET_W-1:0]  r_offset[CFG_REGS];

    logic                        advance;
    logic                        in_range;
    logic [IDX_W-1:0]            sel;
    logic [SENSOR_W-1:0]         sel_off;
    t_unwrap_res                 res;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    assign in_range = r_in_ch < SENSOR_W'(NUM_SENSORS);
    assign sel      = in_range ? r_in_ch[IDX_W-1:0] : '0;
    assign sel_off  = in_range ? r_in_ch : '0;

    mtat_unwrap u_unwrap (
        .i_raw    (r_in_raw),
        .i_last   (r_prev[sel]),
        .i_turns  (r_turns[sel]),
        .i_offset (r_offset[sel_off]),
        .o_res    (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_ch  <= s_axis_tdata[SENSOR_W-1:0];
            r_in_raw <= s_axis_tdata[SENSOR_W +: RAW_W];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_ch    <= r_in_ch;
            r_out_angle <= in_range ? res.angle : '0;
            r_out_turns <= in_range ? res.turns : '0;
        end
    end

    // per-channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_prev[i]  <= '0;
                r_turns[i] <= '0;
            end
        end else if (advance && in_range) begin
            r_prev[sel]  <= r_in_raw;
            r_turns[sel] <= res.turns;
        end
    end

    // zero offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_REGS; i++) begin
                r_offset[i] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(CFG_REGS))) begin
            r_offset[i_cfg_index] <= signed'(i_cfg_data);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - SENSOR_W - ANGLE_W - TURN_W){1'b0}},
                            r_out_turns, r_out_angle, r_out_ch};

    `MTAT_ASSERT(a_out_of_range_zero, i_clk, i_rst_n, (r_out_valid && (r_out_ch >= SENSOR_W'(NUM_SENSORS))) |-> (r_out_angle == '0 && r_out_turns == '0), "out-of-range channel result not zero")
    `MTAT_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready), "input stalled with room in the pipeline")
    `MTAT_ASSERT(a_turn_step_one, i_clk, i_rst_n, (advance && in_range) |-> ((res.turns == r_turns[sel]) || (res.turns == r_turns[sel] + 16'sd1) || (res.turns == r_turns[sel] - 16'sd1)), "turn count moved by more than one")
    `MTAT_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")

endmodule

`default_nettype wire

// ----- hdl/mtat_unwrap.sv -----
// wrap detection, saturating turn update and fixed-point angle for one sample
`timescale 1ns / 1ps
`default_nettype none

module mtat_unwrap
    import mtat_pkg::*;
(
    input  wire logic [RAW_W-1:0]           i_raw,
    input  wire logic [RAW_W-1:0]           i_last,
    input  wire logic signed [TURN_W-1:0]   i_turns,
    input  wire logic signed [OFFSET_W-1:0] i_offset,
    output t_unwrap_res                     o_res
);

    localparam int RAW_PROD_W  = RAW_W + 6;
    localparam int TURN_PROD_W = TURN_W + 6;
    localparam int SUM_W       = ANGLE_W + 1;

    logic                          fwd;
    logic                          bwd;
    logic signed [TURN_W-1:0]      turns_next;
    logic [RAW_PROD_W-1:0]         raw_x45;
    logic signed [TURN_PROD_W-1:0] turns_x45;
    logic signed [SUM_W-1:0]       raw_term;
    logic signed [SUM_W-1:0]       turn_term;
    logic signed [SUM_W-1:0]       off_term;
    logic signed [SUM_W-1:0]       sum;

    assign fwd = (i_raw < WRAP_LOW) && (i_last > WRAP_HIGH) && (i_turns != TURN_MAX);
    assign bwd = (i_raw > WRAP_HIGH) && (i_last < WRAP_LOW) && (i_turns != TURN_MIN);

    always_comb begin
        priority if (fwd) begin
            turns_next = i_turns + 16'sd1;
        end else if (bwd) begin
            turns_next = i_turns - 16'sd1;
        end else begin
            turns_next = i_turns;
        end
    end

    // turns * 184320 is turns * 45 shifted by 12
    assign raw_x45   = RAW_PROD_W'(i_raw) * RAW_PROD_W'(UNITS_PER_COUNT);
    assign turns_x45 = TURN_PROD_W'(turns_next) * TURN_PROD_W'(signed'(UNITS_PER_COUNT));

    assign raw_term  = signed'({{(SUM_W-RAW_PROD_W){1'b0}}, raw_x45});
    assign turn_term = signed'({turns_x45[TURN_PROD_W-1], turns_x45, {TURN_SHIFT{1'b0}}});
    assign off_term  = signed'({{(SUM_W-OFFSET_W){i_offset[OFFSET_W-1]}}, i_offset});
    assign sum       = raw_term + turn_term - off_term;

    assign o_res.turns = turns_next;
    assign o_res.angle = sum[ANGLE_W-1:0];

endmodule

`default_nettype wire

// ----- test/multi_turn_angle_tracker_core_tb.sv -----
// self-checking testbench of the multi-turn angle tracker core
`timescale 1ns / 1ps

module multi_turn_angle_tracker_core_tb;
    import mtat_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(CFG_REGS);
    localparam logic [SENSOR_W-1:0]  BAD_CHANNEL   = SENSOR_W'(NUM_SENSORS_DEF);
    localparam logic [OFFSET_W-1:0]  OFFSET_MIN    = 24'h800000;
    localparam logic [OFFSET_W-1:0]  OFFSET_MAX    = 24'h7fffff;
    localparam int WRAP_ROUNDS  = 25;
    localparam int PHASE_ITEMS  = 410;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct {
        logic [SENSOR_W-1:0]       sensor;
        logic signed [ANGLE_W-1:0] angle;
        logic signed [TURN_W-1:0]  turns;
    } t_unwrap_exp;

    class angle_scoreboard;
        localparam longint UNITS_PER_TURN = longint'(UNITS_PER_COUNT) << TURN_SHIFT;

        longint                   offs[CFG_REGS];
        logic [RAW_W-1:0]         last_raw[NUM_SENSORS_DEF];
        logic signed [TURN_W-1:0] turn_cnt[NUM_SENSORS_DEF];
        t_unwrap_exp              pending_q[$];
        int errors;
        int n_samples;
        int n_checked;
        int n_fwd;
        int n_bwd;
        int n_held;
        int n_bad_ch;

        function new();
            foreach (offs[i]) offs[i] = 0;
            foreach (last_raw[i]) last_raw[i] = '0;
            foreach (turn_cnt[i]) turn_cnt[i] = '0;
            errors = 0;
            n_samples = 0;
            n_checked = 0;
            n_fwd = 0;
            n_bwd = 0;
            n_held = 0;
            n_bad_ch = 0;
        endfunction

        function void write_offset(logic [CFG_IDX_W-1:0] idx, logic [OFFSET_W-1:0] val);
            if (idx < CFG_REGS)
                offs[idx] = longint'(signed'(val));
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // unwrap one sample and queue its expected result
        function void note_sample(logic [SENSOR_W-1:0] ch, logic [RAW_W-1:0] raw);
            t_unwrap_exp e;
            logic signed [TURN_W-1:0] t;
            longint a;
            n_samples++;
            e.sensor = ch;
            e.angle  = '0;
            e.turns  = '0;
            if (ch >= NUM_SENSORS_DEF) begin
                n_bad_ch++;
            end else begin
                t = turn_cnt[ch];
                if (raw < WRAP_LOW && last_raw[ch] > WRAP_HIGH) begin
                    if (t != TURN_MAX) begin
                        t = t + 16'sd1;
                        n_fwd++;
                    end else begin
                        n_held++;
                    end
                end
                if (raw > WRAP_HIGH && last_raw[ch] < WRAP_LOW) begin
                    if (t != TURN_MIN) begin
                        t = t - 16'sd1;
                        n_bwd++;
                    end else begin
                        n_held++;
                    end
                end
                turn_cnt[ch] = t;
                last_raw[ch] = raw;
                a = longint'(raw) * UNITS_PER_COUNT + longint'(t) * UNITS_PER_TURN - offs[ch];
                e.angle = a[ANGLE_W-1:0];
                e.turns = t;
            end
            pending_q.push_back(e);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d);
            t_unwrap_exp e;
            logic [SENSOR_W-1:0]       got_sensor;
            logic signed [ANGLE_W-1:0] got_angle;
            logic signed [TURN_W-1:0]  got_turns;
            got_sensor = d[SENSOR_W-1:0];
            got_angle  = d[SENSOR_W+ANGLE_W-1:SENSOR_W];
            got_turns  = d[SENSOR_W+ANGLE_W+TURN_W-1:SENSOR_W+ANGLE_W];
            if (pending_q.size() == 0) begin
                $error("result with no pending request: tdata %h", d);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            n_checked++;
            if (got_sensor !== e.sensor) begin
                $error("sensor_echo: expected %0d, got %0d", e.sensor, got_sensor);
                errors++;
            end
            if (got_angle !== e.angle) begin
                $error("angle_fixed: expected %0d, got %0d", e.angle, got_angle);
                errors++;
            end
            if (got_turns !== e.turns) begin
                $error("turn_total: expected %0d, got %0d", e.turns, got_turns);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [OFFSET_W-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    angle_scoreboard sb = new();
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int cycles = 0;

    multi_turn_angle_tracker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // all tasks start and end at a falling edge
    task automatic write_offset(input logic [CFG_IDX_W-1:0] idx, input logic [OFFSET_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_offset(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_sample(input logic [SENSOR_W-1:0] ch, input logic [RAW_W-1:0] raw);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, raw, ch};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(ch, raw);
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic reconfigure();
        logic [OFFSET_W-1:0] v;
        for (int i = 0; i < CFG_REGS; i++) begin
            case ($urandom_range(5))
                0: v = OFFSET_MIN;
                1: v = OFFSET_MAX;
                2: v = '0;
                default: v = OFFSET_W'($urandom);
            endcase
            write_offset(CFG_IDX_W'(i), v);
        end
        write_offset(CFG_IDX_SPARE, OFFSET_W'($urandom));
    endtask

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(9))
            0, 1, 2: return RAW_W'($urandom_range(WRAP_LOW - 1));
            3, 4, 5: return RAW_W'($urandom_range(4095, WRAP_HIGH + 1));
            6: begin
                case ($urandom_range(5))
                    0: return RAW_W'(WRAP_LOW - 1);
                    1: return WRAP_LOW;
                    2: return WRAP_HIGH;
                    3: return RAW_W'(WRAP_HIGH + 1);
                    4: return '0;
                    default: return '1;
                endcase
            end
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // mid, then edge, then the opposite edge: one wrap per round
    task automatic wrap_rounds(input logic [SENSOR_W-1:0] ch, input int n, input bit fwd);
        logic [RAW_W-1:0] lo, hi;
        for (int k = 0; k < n; k++) begin
            lo = RAW_W'($urandom_range(WRAP_LOW - 1));
            hi = RAW_W'($urandom_range(4095, WRAP_HIGH + 1));
            send_sample(ch, RAW_W'($urandom_range(WRAP_HIGH, WRAP_LOW)));
            send_sample(ch, fwd ? hi : lo);
            send_sample(ch, fwd ? lo : hi);
        end
    endtask

    task automatic run_random(input int n);
        logic [SENSOR_W-1:0] ch;
        ch = '0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) >= 35)
                ch = ($urandom_range(15) == 0) ? BAD_CHANNEL
                                               : SENSOR_W'($urandom_range(NUM_SENSORS_DEF - 1));
            send_sample(ch, pick_raw());
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_offset(CFG_IDX_W'(0), OFFSET_MIN);
        write_offset(CFG_IDX_W'(1), OFFSET_MAX);
        write_offset(CFG_IDX_W'(2), '0);
        write_offset(CFG_IDX_W'(3), 24'd1);
        write_offset(CFG_IDX_W'(4), '1);
        write_offset(CFG_IDX_W'(5), OFFSET_W'($urandom));
        write_offset(CFG_IDX_W'(6), OFFSET_W'($urandom));
        write_offset(CFG_IDX_SPARE, OFFSET_MAX);

        // thresholds are strict: 100 and 4000 never trigger a wrap
        send_sample(3'd0, 12'd0);
        send_sample(3'd0, 12'd4095);
        send_sample(3'd0, 12'd0);
        send_sample(3'd0, 12'd100);
        send_sample(3'd0, 12'd4001);
        send_sample(3'd0, 12'd99);
        send_sample(3'd0, 12'd4000);
        send_sample(3'd0, 12'd99);
        send_sample(3'd1, 12'd4095);
        send_sample(3'd1, 12'd0);
        send_sample(3'd1, 12'd4095);
        send_sample(BAD_CHANNEL, 12'd4095);
        send_sample(BAD_CHANNEL, 12'd0);
        send_sample(3'd2, 12'd2048);
        send_sample(3'd3, 12'd4001);
        send_sample(3'd4, 12'd99);
        send_sample(3'd4, 12'd4095);
        send_sample(3'd5, 12'd1365);
        send_sample(3'd6, 12'd2730);
        send_sample(3'd6, 12'd0);
        send_sample(3'd6, 12'd4095);
        settle();

        // repeated wraps, up on one channel and down on another
        wrap_rounds(3'd6, WRAP_ROUNDS, 1'b1);
        wrap_rounds(3'd5, WRAP_ROUNDS, 1'b0);
        settle();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
                default: begin src_idle_pct = 29; sink_stall_pct = 29; end
            endcase
            reconfigure();
            run_random(PHASE_ITEMS);
            settle();
        end

        repeat (8) @(negedge i_clk);
        $display("%0d samples sent, %0d results checked, %0d on the unused channel",
                 sb.n_samples, sb.n_checked, sb.n_bad_ch);
        $display("wraps: %0d forward, %0d backward, %0d held at a turn limit",
                 sb.n_fwd, sb.n_bwd, sb.n_held);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
